### src/ipfr_pkg.sv
// Shared types and constants of the IPv4 fragment reassembly tracker.
package ipfr_pkg;

    localparam int START_W = 16;
    localparam int END_W   = 17;

    typedef enum logic [2:0] {
        ST_UNFRAG   = 3'd0,
        ST_STORED   = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_DUP      = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic               more;
        logic [END_W-1:0]   pend;
        logic [START_W-1:0] pstart;
    } t_piece;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_in;
        logic obtain;
        logic idx_clear;
        logic idx_inc;
        logic set_pos_idx;
        logic set_pos_n;
        logic rd_idx;
        logic rd_shift;
        logic wr_shift;
        logic ins;
        logic walk_init;
        logic walk_step;
        logic res_unfrag;
        logic res_full;
        logic res_dup;
        logic res_stored;
        logic res_complete;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic unfrag;
        logic full;
        logic n_zero;
        logic dup;
        logic ahead;
        logic idx_last;
        logic sh_more;
        logic gap;
        logic rd_more;
    } t_sts;

endpackage

### src/ipfr_if.sv
// Fragment input and result output channel interfaces.
interface ipfr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [15:0] frag_ident;
    logic [12:0] frag_off;
    logic [15:0] payload_len;
    logic        more_frags;

    modport source (output valid, src_addr, frag_ident, frag_off, payload_len, more_frags,
                    input ready);
    modport sink (input valid, src_addr, frag_ident, frag_off, payload_len, more_frags,
                  output ready);
endinterface

interface ipfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [3:0]  frag_count;
    logic [16:0] reassembled_len;

    modport source (output valid, status, slot, frag_count, reassembled_len, input ready);
    modport sink (input valid, status, slot, frag_count, reassembled_len, output ready);
endinterface

### src/ipfr_ctrl.sv
// Controller state machine that sequences lookup, scan, shift, insert and walk.
module ipfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  ipfr_pkg::t_sts i_sts,
    output ipfr_pkg::t_cmd o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LOOK  = 11'b000_0000_0010,
        S_CHECK = 11'b000_0000_0100,
        S_SC_RD = 11'b000_0000_1000,
        S_SC_EV = 11'b000_0001_0000,
        S_SH_RD = 11'b000_0010_0000,
        S_SH_WR = 11'b000_0100_0000,
        S_INS   = 11'b000_1000_0000,
        S_WK_RD = 11'b001_0000_0000,
        S_WK_EV = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.unfrag) begin
                    o_cmd.res_unfrag = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.obtain = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.idx_clear = 1'b1;
                if (i_sts.full) begin
                    o_cmd.res_full = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.n_zero) begin
                    o_cmd.set_pos_n = 1'b1;
                    n_state = S_INS;
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                o_cmd.rd_idx = 1'b1;
                n_state = S_SC_EV;
            end
            S_SC_EV: begin
                if (i_sts.dup) begin
                    o_cmd.res_dup = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.ahead) begin
                    o_cmd.set_pos_idx = 1'b1;
                    n_state = S_SH_RD;
                end else if (i_sts.idx_last) begin
                    o_cmd.set_pos_n = 1'b1;
                    n_state = S_INS;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_SH_RD: begin
                o_cmd.rd_shift = 1'b1;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state = i_sts.sh_more ? S_SH_RD : S_INS;
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                o_cmd.walk_init = 1'b1;
                n_state = S_WK_RD;
            end
            S_WK_RD: begin
                o_cmd.rd_idx = 1'b1;
                n_state = S_WK_EV;
            end
            S_WK_EV: begin
                if (i_sts.gap) begin
                    o_cmd.res_stored = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.idx_last) begin
                    if (i_sts.rd_more) begin
                        o_cmd.res_stored = 1'b1;
                    end else begin
                        o_cmd.res_complete = 1'b1;
                    end
                    n_state = S_OUT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state = S_WK_RD;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

### src/ipfr_datapath.sv
// Datapath: context table, LRU ages, piece memory and result registers.
module ipfr_datapath #(
    parameter int CONTEXTS           = 8,
    parameter int PIECES_PER_CONTEXT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ipfr_pkg::t_cmd i_cmd,
    output ipfr_pkg::t_sts o_sts,
    input  logic [31:0]    i_src_addr,
    input  logic [15:0]    i_frag_ident,
    input  logic [12:0]    i_frag_off,
    input  logic [15:0]    i_payload_len,
    input  logic           i_more_frags,
    output logic [2:0]     o_status,
    output logic [2:0]     o_slot,
    output logic [3:0]     o_frag_count,
    output logic [16:0]    o_reassembled_len
);

    localparam int SW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int NW    = $clog2(PIECES_PER_CONTEXT + 1);
    localparam int DEPTH = CONTEXTS * PIECES_PER_CONTEXT;
    localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = ipfr_pkg::END_W;

    // Context table
    logic [CONTEXTS-1:0] r_valid;
    logic [31:0]         r_src   [CONTEXTS];
    logic [15:0]         r_id    [CONTEXTS];
    logic [SW-1:0]       r_age   [CONTEXTS];
    logic [NW-1:0]       r_count [CONTEXTS];

    // Latched fragment
    logic [31:0]                  r_in_src;
    logic [15:0]                  r_in_id;
    logic [ipfr_pkg::START_W-1:0] r_start;
    logic [EW-1:0]                r_end;
    logic                         r_mf;
    logic                         r_unfrag;

    // Work registers
    logic [SW-1:0]   r_slot;
    logic [NW-1:0]   r_n;
    logic [NW-1:0]   r_idx;
    logic [NW-1:0]   r_pos;
    logic [NW-1:0]   r_j;
    logic [EW-1:0]   r_run;
    ipfr_pkg::t_piece r_rd;

    // Results
    ipfr_pkg::t_status r_status;
    logic [SW-1:0]     r_res_slot;
    logic [NW-1:0]     r_res_cnt;
    logic [EW-1:0]     r_res_len;

    // Piece memory
    ipfr_pkg::t_piece mem [DEPTH];

    function automatic logic [MW-1:0] piece_addr(input logic [SW-1:0] slot,
                                                  input logic [NW-1:0] idx);
        piece_addr = MW'(slot) * MW'(PIECES_PER_CONTEXT) + MW'(idx);
    endfunction

    // Search the context table
    logic [CONTEXTS-1:0] hit;
    logic [SW-1:0]       h_idx, f_idx, l_idx, obt_slot;
    logic                h_any, f_any, l_any;
    logic [NW-1:0]       obt_n;

    always_comb begin
        h_idx = '0; f_idx = '0; l_idx = '0;
        h_any = 1'b0; f_any = 1'b0; l_any = 1'b0;
        for (int i = 0; i < CONTEXTS; i++) begin
            hit[i] = r_valid[i] && (r_src[i] == r_in_src) && (r_id[i] == r_in_id);
            if (hit[i] && !h_any) begin
                h_idx = SW'(i);
                h_any = 1'b1;
            end
            if (!r_valid[i] && !f_any) begin
                f_idx = SW'(i);
                f_any = 1'b1;
            end
            if (r_valid[i] && (r_age[i] == SW'(CONTEXTS - 1)) && !l_any) begin
                l_idx = SW'(i);
                l_any = 1'b1;
            end
        end
        obt_slot = h_any ? h_idx : (f_any ? f_idx : l_idx);
        obt_n    = h_any ? r_count[h_idx] : '0;
    end

    // Update valid bits, ages and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < CONTEXTS; i++) begin
                r_age[i]   <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cmd.obtain) begin
                for (int i = 0; i < CONTEXTS; i++) begin
                    if (r_valid[i] && (SW'(i) != obt_slot) &&
                        (!h_any || (r_age[i] < r_age[h_idx]))) begin
                        r_age[i] <= r_age[i] + SW'(1);
                    end
                end
                r_age[obt_slot]   <= '0;
                r_valid[obt_slot] <= 1'b1;
                if (!h_any) begin
                    r_count[obt_slot] <= '0;
                end
            end
            if (i_cmd.ins) begin
                r_count[r_slot] <= r_n + NW'(1);
            end
            if (i_cmd.res_complete) begin
                for (int i = 0; i < CONTEXTS; i++) begin
                    if (r_valid[i] && (SW'(i) != r_slot) && (r_age[i] > r_age[r_slot])) begin
                        r_age[i] <= r_age[i] - SW'(1);
                    end
                end
                r_valid[r_slot] <= 1'b0;
                r_age[r_slot]   <= '0;
                r_count[r_slot] <= '0;
            end
        end
    end

    // Write context keys
    always_ff @(posedge i_clk) begin
        if (i_cmd.obtain && !h_any) begin
            r_src[obt_slot] <= r_in_src;
            r_id[obt_slot]  <= r_in_id;
        end
    end

    // Latch fragment and advance work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_src <= i_src_addr;
            r_in_id  <= i_frag_ident;
            r_start  <= {i_frag_off, 3'b000};
            r_end    <= {1'b0, i_frag_off, 3'b000} + {1'b0, i_payload_len};
            r_mf     <= i_more_frags;
            r_unfrag <= (i_frag_off == 13'd0) && !i_more_frags;
        end
        if (i_cmd.obtain) begin
            r_slot <= obt_slot;
            r_n    <= obt_n;
        end
        if (i_cmd.idx_clear || i_cmd.walk_init) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc || i_cmd.walk_step) begin
            r_idx <= r_idx + NW'(1);
        end
        if (i_cmd.set_pos_idx) begin
            r_pos <= r_idx;
            r_j   <= r_n;
        end else if (i_cmd.set_pos_n) begin
            r_pos <= r_n;
        end else if (i_cmd.wr_shift) begin
            r_j <= r_j - NW'(1);
        end
        if (i_cmd.ins) begin
            r_n <= r_n + NW'(1);
        end
        if (i_cmd.walk_init) begin
            r_run <= '0;
        end else if (i_cmd.walk_step) begin
            r_run <= r_rd.pend;
        end
    end

    // Piece memory write and registered read
    logic             mem_we, mem_re;
    logic [MW-1:0]    wa, ra;
    ipfr_pkg::t_piece wd;

    always_comb begin
        mem_we = i_cmd.wr_shift || i_cmd.ins;
        mem_re = i_cmd.rd_idx || i_cmd.rd_shift;
        if (i_cmd.ins) begin
            wa = piece_addr(r_slot, r_pos);
            wd = '{more: r_mf, pend: r_end, pstart: r_start};
        end else begin
            wa = piece_addr(r_slot, r_j);
            wd = r_rd;
        end
        ra = i_cmd.rd_shift ? piece_addr(r_slot, r_j - NW'(1)) : piece_addr(r_slot, r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wa] <= wd;
        end
        if (mem_re) begin
            r_rd <= mem[ra];
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_unfrag) begin
            r_status   <= ipfr_pkg::ST_UNFRAG;
            r_res_slot <= '0;
            r_res_cnt  <= '0;
            r_res_len  <= '0;
        end else if (i_cmd.res_full || i_cmd.res_dup || i_cmd.res_stored) begin
            r_status   <= i_cmd.res_full ? ipfr_pkg::ST_FULL :
                          (i_cmd.res_dup ? ipfr_pkg::ST_DUP : ipfr_pkg::ST_STORED);
            r_res_slot <= r_slot;
            r_res_cnt  <= r_n;
            r_res_len  <= '0;
        end else if (i_cmd.res_complete) begin
            r_status   <= ipfr_pkg::ST_COMPLETE;
            r_res_slot <= r_slot;
            r_res_cnt  <= '0;
            r_res_len  <= r_rd.pend;
        end
    end

    // Report status
    always_comb begin
        o_sts.unfrag   = r_unfrag;
        o_sts.full     = ((NW+1)'(r_n) >= (NW+1)'(PIECES_PER_CONTEXT));
        o_sts.n_zero   = (r_n == '0);
        o_sts.dup      = (r_rd.pstart == r_start);
        o_sts.ahead    = (r_end <= {1'b0, r_rd.pstart});
        o_sts.idx_last = (((NW+1)'(r_idx) + (NW+1)'(1)) == (NW+1)'(r_n));
        o_sts.sh_more  = ((NW+1)'(r_j) > ((NW+1)'(r_pos) + (NW+1)'(1)));
        o_sts.gap      = ({1'b0, r_rd.pstart} != r_run);
        o_sts.rd_more  = r_rd.more;
    end

    assign o_status          = r_status;
    assign o_slot            = 3'(r_res_slot);
    assign o_frag_count      = 4'(r_res_cnt);
    assign o_reassembled_len = r_res_len;

endmodule

### src/ip_fragment_reassembly_tracker.sv
// Top level of the IPv4 fragment reassembly tracker.
// Takes one fragment at a time and returns one result transaction per fragment;
// the next fragment is accepted in the cycle after the result has been taken.
// An unfragmented item is answered straight after the lookup, a full context
// after the occupancy check and a duplicate start during the scan; a stored or
// completed fragment passes through the scan for the insert position, the shift,
// the insert and the contiguity walk. The scan reads k held pieces, the shift
// moves m pieces up and the walk reads w pieces, each step being one read of the
// piece memory plus its evaluation or write-back. With eight pieces per context
// k + m and w are each at most 8. Up to CONTEXTS contexts are tracked with
// least-recent eviction, each holding up to PIECES_PER_CONTEXT pieces; no
// clearing pass is needed after reset.
module ip_fragment_reassembly_tracker #(
    parameter int CONTEXTS           = 8,
    parameter int PIECES_PER_CONTEXT = 8
) (
    input logic         i_clk,
    input logic         i_rst_n,
    ipfr_in_if.sink     i_frag,
    ipfr_out_if.source  o_res
);

    ipfr_pkg::t_cmd cmd;
    ipfr_pkg::t_sts sts;

    ipfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_frag.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (i_frag.ready),
        .o_out_valid (o_res.valid)
    );

    ipfr_datapath #(
        .CONTEXTS           (CONTEXTS),
        .PIECES_PER_CONTEXT (PIECES_PER_CONTEXT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_src_addr        (i_frag.src_addr),
        .i_frag_ident      (i_frag.frag_ident),
        .i_frag_off        (i_frag.frag_off),
        .i_payload_len     (i_frag.payload_len),
        .i_more_frags      (i_frag.more_frags),
        .o_status          (o_res.status),
        .o_slot            (o_res.slot),
        .o_frag_count      (o_res.frag_count),
        .o_reassembled_len (o_res.reassembled_len)
    );

endmodule

### src/ipfr_checker.sv
// Port-level checks of the tracker and their binding to the top level.
module ipfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [2:0]  i_slot,
    input logic [3:0]  i_frag_count,
    input logic [16:0] i_len
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_len))
        else $error("result changed while stalled");

    // Take one fragment at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("fragment accepted while one is in progress");

    // Unfragmented result carries zero fields
    a_unfrag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ipfr_pkg::ST_UNFRAG |->
            i_slot == 3'd0 && i_frag_count == 4'd0 && i_len == 17'd0)
        else $error("unfragmented result with nonzero fields");

    // Complete result frees the context
    a_complete_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ipfr_pkg::ST_COMPLETE |-> i_frag_count == 4'd0)
        else $error("complete result with pieces left");

    // Drop length on all but complete
    a_len_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ipfr_pkg::ST_COMPLETE |-> i_len == 17'd0)
        else $error("length reported without completion");

endmodule

bind ip_fragment_reassembly_tracker ipfr_checker u_ipfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_frag.valid),
    .i_in_ready   (i_frag.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_slot       (o_res.slot),
    .i_frag_count (o_res.frag_count),
    .i_len        (o_res.reassembled_len)
);

### verif/ipfr_tb_if.sv
`timescale 1ns / 100ps
// Fragment transaction type used by the testbench.
package ipfr_tb_types;
    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] frag_ident;
        logic [12:0] frag_off;
        logic [15:0] payload_len;
        logic        more_frags;
    } t_frag;
endpackage

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the IPv4 fragment reassembly tracker.
module testbench;

    localparam int NCTX = 8;
    localparam int NPC = 8;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [3:0]  frag_count;
        logic [16:0] reassembled_len;
    } t_res;

    // Tracker prediction plus queue of pending results
    class frag_scoreboard;
        bit          live[NCTX];
        logic [31:0] key_src[NCTX];
        logic [15:0] key_id[NCTX];
        int          rank[NCTX];
        int          held[NCTX];
        int          pc_start[NCTX][NPC];
        int          pc_end[NCTX][NPC];
        bit          pc_more[NCTX][NPC];
        t_res        pending[$];
        int          errors;
        int          checked;
        int          n_complete;
        int          n_dup;
        int          n_full;

        function void promote(int s);
            int a;
            a = rank[s];
            for (int i = 0; i < NCTX; i++)
                if (live[i] && i != s && rank[i] < a) rank[i]++;
            rank[s] = 0;
        endfunction

        function void free_ctx(int s);
            int a;
            a = rank[s];
            for (int i = 0; i < NCTX; i++)
                if (live[i] && i != s && rank[i] > a) rank[i]--;
            live[s] = 0;
            rank[s] = 0;
            held[s] = 0;
        endfunction

        function int find_ctx(logic [31:0] src, logic [15:0] id);
            int s;
            s = -1;
            for (int i = 0; i < NCTX; i++)
                if (live[i] && key_src[i] == src && key_id[i] == id) begin
                    promote(i);
                    return i;
                end
            for (int i = 0; i < NCTX; i++)
                if (!live[i]) begin
                    s = i;
                    break;
                end
            if (s >= 0) begin
                for (int i = 0; i < NCTX; i++)
                    if (live[i]) rank[i]++;
                live[s] = 1;
                rank[s] = 0;
            end else begin
                s = 0;
                for (int i = 1; i < NCTX; i++)
                    if (rank[i] > rank[s]) s = i;
                promote(s);
            end
            key_src[s] = src;
            key_id[s] = id;
            held[s] = 0;
            return s;
        endfunction

        // Note an accepted fragment and queue its expected result
        function void note_fragment(ipfr_tb_types::t_frag f);
            t_res r;
            int s, n, pos, st, en, run;
            bit whole;
            r = '0;
            if (f.frag_off != 0 || f.more_frags) begin
                s = find_ctx(f.src_addr, f.frag_ident);
                r.slot = s[2:0];
                st = int'(f.frag_off) * 8;
                en = (st + int'(f.payload_len)) & 17'h1ffff;
                n = held[s];
                r.frag_count = n[3:0];
                if (n >= NPC) begin
                    r.status = ipfr_pkg::ST_FULL;
                    n_full++;
                end else begin
                    pos = n;
                    r.status = ipfr_pkg::ST_STORED;
                    for (int i = 0; i < n; i++) begin
                        if (st == pc_start[s][i]) begin
                            r.status = ipfr_pkg::ST_DUP;
                            break;
                        end
                        if (en <= pc_start[s][i]) begin
                            pos = i;
                            break;
                        end
                    end
                    if (r.status == ipfr_pkg::ST_DUP) n_dup++;
                    else begin
                        for (int i = n; i > pos; i--) begin
                            pc_start[s][i] = pc_start[s][i-1];
                            pc_end[s][i] = pc_end[s][i-1];
                            pc_more[s][i] = pc_more[s][i-1];
                        end
                        pc_start[s][pos] = st;
                        pc_end[s][pos] = en;
                        pc_more[s][pos] = f.more_frags;
                        n++;
                        held[s] = n;
                        run = 0;
                        whole = 1;
                        for (int i = 0; i < n; i++) begin
                            if (pc_start[s][i] != run) begin
                                whole = 0;
                                break;
                            end
                            run = pc_end[s][i];
                        end
                        if (whole && !pc_more[s][n-1]) begin
                            free_ctx(s);
                            r.status = ipfr_pkg::ST_COMPLETE;
                            r.reassembled_len = run[16:0];
                            r.frag_count = 0;
                            n_complete++;
                        end else r.frag_count = n[3:0];
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // Compare one result against the oldest expectation
        task check_result(t_res got);
            t_res e;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("result with none pending", 32'd0, 32'(got));
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report_mismatch("status", 32'(e.status), 32'(got.status));
            if (got.slot !== e.slot)
                report_mismatch("slot", 32'(e.slot), 32'(got.slot));
            if (got.frag_count !== e.frag_count)
                report_mismatch("frag_count", 32'(e.frag_count), 32'(got.frag_count));
            if (got.reassembled_len !== e.reassembled_len)
                report_mismatch("reassembled_len", 32'(e.reassembled_len),
                                32'(got.reassembled_len));
        endtask

        task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            if (errors <= 40)
                $display("mismatch on result %0d: %s expected %0h got %0h",
                         checked, what, exp_v, got_v);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ipfr_in_if  frag_ch ();
    ipfr_out_if res_ch ();
    frag_scoreboard sb;
    int idle_cycles = 0;
    bit hold_off = 0;

    ip_fragment_reassembly_tracker DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_frag (frag_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        frag_ch.valid = 0;
        frag_ch.src_addr = 0;
        frag_ch.frag_ident = 0;
        frag_ch.frag_off = 0;
        frag_ch.payload_len = 0;
        frag_ch.more_frags = 0;
        res_ch.ready = 0;
    end

    // Offer one fragment after a random gap and hold it until taken
    task automatic send_frag(ipfr_tb_types::t_frag f);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            frag_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        frag_ch.valid <= 1;
        frag_ch.src_addr <= f.src_addr;
        frag_ch.frag_ident <= f.frag_ident;
        frag_ch.frag_off <= f.frag_off;
        frag_ch.payload_len <= f.payload_len;
        frag_ch.more_frags <= f.more_frags;
        do @(posedge i_clk); while (!frag_ch.ready);
        sb.note_fragment(f);
    endtask

    function automatic ipfr_tb_types::t_frag mk(logic [31:0] s, logic [15:0] id, int off,
                                                int len, bit mf);
        ipfr_tb_types::t_frag f;
        f.src_addr = s;
        f.frag_ident = id;
        f.frag_off = off[12:0];
        f.payload_len = len[15:0];
        f.more_frags = mf;
        return f;
    endfunction

    // Send one datagram split into pieces, in a random order, sometimes broken
    task automatic send_datagram(logic [31:0] s, logic [15:0] id);
        int np, off, len;
        ipfr_tb_types::t_frag q[$];
        np = $urandom_range(1, 9);
        off = 0;
        for (int i = 0; i < np; i++) begin
            len = ($urandom_range(1, 6)) * 8;
            if (i == np - 1) len = $urandom_range(0, 60);
            q.push_back(mk(s, id, off, len, i != np - 1));
            off += len / 8;
        end
        q.shuffle();
        if ($urandom_range(0, 4) == 0) q.push_back(q[$urandom_range(0, q.size() - 1)]);
        if ($urandom_range(0, 6) == 0) void'(q.pop_back());
        foreach (q[i]) send_frag(q[i]);
    endtask

    // Result side with random stalls and one long hold-off
    initial begin
        t_res r;
        int w;
        @(posedge i_rst_n);
        forever begin
            w = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (hold_off || w > 0) begin
                res_ch.ready <= 0;
                while (hold_off) @(posedge i_clk);
                repeat (w) @(posedge i_clk);
            end
            res_ch.ready <= 1;
            do @(posedge i_clk); while (!res_ch.valid);
            r.status = res_ch.status;
            r.slot = res_ch.slot;
            r.frag_count = res_ch.frag_count;
            r.reassembled_len = res_ch.reassembled_len;
            sb.check_result(r);
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((frag_ch.valid && frag_ch.ready) || (res_ch.valid && res_ch.ready) || hold_off)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.pending.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] base;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: field extremes, unfragmented, duplicate, full, eviction
        send_frag(mk(32'h0, 16'h0, 0, 0, 0));
        send_frag(mk(32'hffffffff, 16'hffff, 0, 65515, 0));
        send_frag(mk(32'hffffffff, 16'hffff, 8191, 65535, 1));
        send_frag(mk(32'hffffffff, 16'hffff, 8191, 65535, 0));
        send_frag(mk(32'hffffffff, 16'hffff, 0, 65535, 1));
        send_frag(mk(32'h1, 16'h1, 1, 8, 0));
        send_frag(mk(32'h1, 16'h1, 0, 8, 1));
        for (int i = 0; i < 9; i++) send_frag(mk(32'h2, 16'h2, 2 * i + 1, 8, 1));
        for (int i = 0; i < 8; i++) send_frag(mk(32'h100 + i, 16'h5, 3, 8, 1));

        // Long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 4; i++) send_frag(mk(32'h300, 16'h3, i, 8, 1));
        join

        // Random: mostly well-formed datagrams over a small key set, some noise
        base = $urandom;
        while (sb.checked + sb.pending.size() < 420) begin
            if ($urandom_range(0, 9) < 8)
                send_datagram(base + $urandom_range(0, 11), 16'($urandom_range(0, 3)));
            else
                send_frag(mk($urandom, 16'($urandom), $urandom_range(0, 8191),
                             $urandom_range(0, 65535), 1'($urandom_range(0, 1))));
        end
        frag_ch.valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("covered %0d fragments: %0d complete, %0d duplicate, %0d full",
                 sb.checked, sb.n_complete, sb.n_dup, sb.n_full);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

### sim.f
src/ipfr_pkg.sv
src/ipfr_if.sv
src/ipfr_ctrl.sv
src/ipfr_datapath.sv
src/ip_fragment_reassembly_tracker.sv
src/ipfr_checker.sv
verif/ipfr_tb_if.sv
verif/testbench.sv
